// ----- sv/wav_pkg.sv -----
// Shared types and constants for the WAV PCM stream decoder.
package wav_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [4:0]  FMT_BODY = 5'd20;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam int          QUEUE_DEPTH = 4;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NO_RIFF  = 3'd0;
  localparam logic [2:0] ERR_NO_WAVE  = 3'd1;
  localparam logic [2:0] ERR_NO_FMT   = 3'd2;
  localparam logic [2:0] ERR_NOT_PCM  = 3'd3;
  localparam logic [2:0] ERR_NO_DATA  = 3'd4;
  localparam logic [2:0] ERR_BAD_FMT  = 3'd5;

  typedef enum logic [3:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_FID, PH_FSIZE, PH_FSKIP, PH_FMT,
    PH_DID, PH_DSIZE, PH_DSKIP, PH_DLEN, PH_SAMP, PH_IDLE
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] sample_value;
    logic [15:0] channel;
    logic        last_sample;
    logic [31:0] rate_report;
    logic [15:0] width_report;
    logic [15:0] channels_report;
    logic [2:0]  error_code;
  } result_t;

endpackage

// ----- sv/wav_pcm_stream_decoder_top.sv -----
// Top level of the WAV PCM stream decoder.
// A result enters the queue at the edge that takes its byte and, once it is the
// oldest entry in the queue, sits on the result ports and can be popped.
// Throughput: one byte per cycle while the result queue has room.
// Reset: rst clears parser state and empties the queue; file_start restarts
// the parse at the byte that carries it.
module wav_pcm_stream_decoder_top import wav_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        file_start,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind,
  output logic [31:0] sample_value,
  output logic [15:0] channel,
  output logic        last_sample,
  output logic [31:0] rate_report,
  output logic [15:0] width_report,
  output logic [15:0] channels_report,
  output logic [2:0]  error_code
);

  logic    take, res_valid;
  result_t res, head;

  assign take = push && !full;

  wav_front u_front (
    .clk, .rst, .take, .data_byte, .file_start, .res_valid, .res
  );

  wav_queue #(.DEPTH(DEPTH)) u_queue (
    .clk, .rst, .wr(take && res_valid), .wdata(res), .rd(pop),
    .rdata(head), .full, .empty
  );

  // unpack the head word
  assign kind            = head.kind;
  assign sample_value    = head.sample_value;
  assign channel         = head.channel;
  assign last_sample     = head.last_sample;
  assign rate_report     = head.rate_report;
  assign width_report    = head.width_report;
  assign channels_report = head.channels_report;
  assign error_code      = head.error_code;

endmodule

// ----- sv/wav_front.sv -----
// Byte parser: walks the RIFF/WAVE structure and builds result words.
module wav_front import wav_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  data_byte,
  input  logic        file_start,
  output logic        res_valid,
  output result_t     res
);

  phase_t      parse_phase, parse_phase_next;
  logic [1:0]  field_bytes_seen, field_bytes_seen_next;
  logic [31:0] field_accum, field_accum_next;
  logic [31:0] stream_position, stream_position_next;
  logic [31:0] riff_end, riff_end_next;
  logic [31:0] skip_remaining, skip_remaining_next;
  logic [15:0] chan_count, chan_count_next;
  logic [31:0] rate_value, rate_value_next;
  logic [15:0] align_bytes, align_bytes_next;
  logic [15:0] width_bits, width_bits_next;
  logic [31:0] data_remaining, data_remaining_next;
  logic [31:0] sample_accum, sample_accum_next;
  logic [2:0]  byte_in_sample, byte_in_sample_next;
  logic [15:0] chan_index, chan_index_next;
  logic [15:0] byte_in_block, byte_in_block_next;

  // working values after an optional restart
  phase_t      c_ph;
  logic [1:0]  c_fbs, fbs_inc;
  logic [31:0] c_fa, fa_sh, c_pos, pos_n, c_rend, c_skip, c_rate, c_dr, c_sacc;
  logic [15:0] c_cc, c_al, c_wb, c_ci, c_bib;
  logic [2:0]  c_bis, bis_inc;
  logic        len4, fdone, can_search;
  logic [4:0]  off;
  logic [32:0] rend_sum;
  logic [2:0]  bps;
  logic [31:0] sacc_sh, offs, ext;
  logic [32:0] ones_sh;
  logic [16:0] ci_inc, bib_inc;
  logic [33:0] after;
  logic [18:0] need;

  always_comb begin
    c_ph   = file_start ? PH_RIFF : parse_phase;
    c_fbs  = file_start ? 2'd0  : field_bytes_seen;
    c_fa   = file_start ? 32'd0 : field_accum;
    c_pos  = file_start ? 32'd0 : stream_position;
    c_rend = file_start ? 32'd0 : riff_end;
    c_skip = file_start ? 32'd0 : skip_remaining;
    c_cc   = file_start ? 16'd0 : chan_count;
    c_rate = file_start ? 32'd0 : rate_value;
    c_al   = file_start ? 16'd0 : align_bytes;
    c_wb   = file_start ? 16'd0 : width_bits;
    c_dr   = file_start ? 32'd0 : data_remaining;
    c_sacc = file_start ? 32'd0 : sample_accum;
    c_bis  = file_start ? 3'd0  : byte_in_sample;
    c_ci   = file_start ? 16'd0 : chan_index;
    c_bib  = file_start ? 16'd0 : byte_in_block;

    pos_n = (c_pos == ALL_ONES) ? c_pos : c_pos + 32'd1;
    can_search = ({1'b0, pos_n} + 33'd4) < {1'b0, c_rend};
    fa_sh = c_fa | ({24'd0, data_byte} << {c_fbs, 3'b000});
    fbs_inc = c_fbs + 2'd1;
    off = FMT_BODY - c_skip[4:0];
    len4 = (c_ph != PH_FMT) || (off < 5'd4) || (off >= 5'd8 && off < 5'd16);
    fdone = len4 ? (fbs_inc == 2'd0) : (fbs_inc == 2'd2);
    rend_sum = {1'b0, fa_sh} + {1'b0, pos_n};
    bps = c_wb[5:3];
    bis_inc = c_bis + 3'd1;
    sacc_sh = c_sacc | ({24'd0, data_byte} << {c_bis[1:0], 3'b000});
    offs = (c_wb == 16'd8) ? 32'd0 : (32'd1 << (c_wb[4:0] - 5'd1));
    ones_sh = {1'b0, ALL_ONES} << c_wb[5:0];
    ext = (bps > 3'd1 && sacc_sh >= offs) ? (sacc_sh | ones_sh[31:0]) : sacc_sh;
    ci_inc = {1'b0, c_ci} + 17'd1;
    bib_inc = {1'b0, c_bib} + 17'd1;
    after = {2'b00, c_dr} + {18'd0, c_bib} - {18'd0, c_al};
    need = {3'd0, c_cc} * {16'd0, fa_sh[5:3]};

    parse_phase_next      = c_ph;
    field_bytes_seen_next = c_fbs;
    field_accum_next      = c_fa;
    stream_position_next  = pos_n;
    riff_end_next         = c_rend;
    skip_remaining_next   = c_skip;
    chan_count_next       = c_cc;
    rate_value_next       = c_rate;
    align_bytes_next      = c_al;
    width_bits_next       = c_wb;
    data_remaining_next   = c_dr;
    sample_accum_next     = c_sacc;
    byte_in_sample_next   = c_bis;
    chan_index_next       = c_ci;
    byte_in_block_next    = c_bib;
    res_valid = 1'b0;
    res = '0;

    // shared field assembly for every header phase except the skip phases
    if (c_ph != PH_SAMP && c_ph != PH_IDLE && c_ph != PH_FSKIP && c_ph != PH_DSKIP) begin
      if (fdone) begin
        field_accum_next = 32'd0;
        field_bytes_seen_next = 2'd0;
      end else begin
        field_accum_next = fa_sh;
        field_bytes_seen_next = fbs_inc;
      end
    end

    case (c_ph)
      PH_RIFF: begin
        if (fdone) begin
          if (fa_sh != TAG_RIFF) begin
            res_valid = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_NO_RIFF;
            parse_phase_next = PH_IDLE;
          end else parse_phase_next = PH_RSIZE;
        end
      end
      PH_RSIZE: begin
        if (fdone) begin
          riff_end_next = rend_sum[32] ? ALL_ONES : rend_sum[31:0];
          parse_phase_next = PH_WAVE;
        end
      end
      PH_WAVE: begin
        if (fdone) begin
          if (fa_sh != TAG_WAVE) begin
            res_valid = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_NO_WAVE;
            parse_phase_next = PH_IDLE;
          end else if (can_search) parse_phase_next = PH_FID;
          else begin
            res_valid = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_NO_FMT;
            parse_phase_next = PH_IDLE;
          end
        end
      end
      PH_FID, PH_DID: begin
        if (fdone) begin
          if (c_ph == PH_FID && fa_sh == TAG_FMT) begin
            parse_phase_next = PH_FMT;
            skip_remaining_next = {27'd0, FMT_BODY};
          end else if (c_ph == PH_DID && fa_sh == TAG_DATA) parse_phase_next = PH_DLEN;
          else parse_phase_next = (c_ph == PH_FID) ? PH_FSIZE : PH_DSIZE;
        end
      end
      PH_FSIZE, PH_DSIZE: begin
        if (fdone) begin
          skip_remaining_next = fa_sh;
          if (fa_sh != 32'd0) parse_phase_next = (c_ph == PH_FSIZE) ? PH_FSKIP : PH_DSKIP;
          else if (can_search) parse_phase_next = (c_ph == PH_FSIZE) ? PH_FID : PH_DID;
          else begin
            res_valid = 1'b1; res.kind = KIND_ERROR;
            res.error_code = (c_ph == PH_FSIZE) ? ERR_NO_FMT : ERR_NO_DATA;
            parse_phase_next = PH_IDLE;
          end
        end
      end
      PH_FSKIP, PH_DSKIP: begin
        if (c_skip != 32'd0) skip_remaining_next = c_skip - 32'd1;
        if (c_skip <= 32'd1) begin
          field_accum_next = 32'd0;
          field_bytes_seen_next = 2'd0;
          if (can_search) parse_phase_next = (c_ph == PH_FSKIP) ? PH_FID : PH_DID;
          else begin
            res_valid = 1'b1; res.kind = KIND_ERROR;
            res.error_code = (c_ph == PH_FSKIP) ? ERR_NO_FMT : ERR_NO_DATA;
            parse_phase_next = PH_IDLE;
          end
        end
      end
      PH_FMT: begin
        if (c_skip != 32'd0) skip_remaining_next = c_skip - 32'd1;
        if (fdone) begin
          case (off)
            5'd3, 5'd5: begin
              if (fa_sh != ((off == 5'd3) ? 32'd16 : 32'd1)) begin
                res_valid = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_NOT_PCM;
                parse_phase_next = PH_IDLE;
              end
            end
            5'd7:  chan_count_next = fa_sh[15:0];
            5'd11: rate_value_next = fa_sh;
            5'd17: align_bytes_next = fa_sh[15:0];
            5'd19: begin
              width_bits_next = fa_sh[15:0];
              if (fa_sh[15:0] < 16'd8 || fa_sh[15:0] > 16'd32 || c_al == 16'd0 ||
                  {3'd0, c_al} < need) begin
                res_valid = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_BAD_FMT;
                parse_phase_next = PH_IDLE;
              end else if (can_search) parse_phase_next = PH_DID;
              else begin
                res_valid = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_NO_DATA;
                parse_phase_next = PH_IDLE;
              end
            end
            default: ;
          endcase
        end
      end
      PH_DLEN: begin
        if (fdone) begin
          data_remaining_next = fa_sh;
          sample_accum_next = 32'd0;
          byte_in_sample_next = 3'd0;
          chan_index_next = 16'd0;
          byte_in_block_next = 16'd0;
          parse_phase_next = (c_al == 16'd0 || fa_sh < {16'd0, c_al}) ? PH_IDLE : PH_SAMP;
          res_valid = 1'b1;
          res.kind = KIND_REPORT;
          res.rate_report = c_rate;
          res.width_report = c_wb;
          res.channels_report = c_cc;
        end
      end
      PH_SAMP: begin
        // assemble a sample, then convert it to offset binary
        if (c_ci < c_cc && bps >= 3'd1 && bps <= 3'd4) begin
          sample_accum_next = sacc_sh;
          byte_in_sample_next = bis_inc;
          if (bis_inc >= bps) begin
            res_valid = 1'b1;
            res.kind = KIND_SAMPLE;
            res.sample_value = ext + offs;
            res.channel = c_ci;
            res.last_sample = (ci_inc == {1'b0, c_cc}) && !after[33] &&
                              (after < {18'd0, c_al});
            chan_index_next = ci_inc[15:0];
            byte_in_sample_next = 3'd0;
            sample_accum_next = 32'd0;
          end
        end
        byte_in_block_next = bib_inc[15:0];
        if (c_dr != 32'd0) data_remaining_next = c_dr - 32'd1;
        // close the block and drop its padding
        if (bib_inc >= {1'b0, c_al}) begin
          byte_in_block_next = 16'd0;
          chan_index_next = 16'd0;
          byte_in_sample_next = 3'd0;
          sample_accum_next = 32'd0;
          if (data_remaining_next < {16'd0, c_al} || c_al == 16'd0)
            parse_phase_next = PH_IDLE;
        end
      end
      default: ;
    endcase
  end

  // advance the parse on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= PH_RIFF;
      field_bytes_seen <= '0;
      field_accum <= '0;
      stream_position <= '0;
      riff_end <= '0;
      skip_remaining <= '0;
      chan_count <= '0;
      rate_value <= '0;
      align_bytes <= '0;
      width_bits <= '0;
      data_remaining <= '0;
      sample_accum <= '0;
      byte_in_sample <= '0;
      chan_index <= '0;
      byte_in_block <= '0;
    end else if (take) begin
      parse_phase <= parse_phase_next;
      field_bytes_seen <= field_bytes_seen_next;
      field_accum <= field_accum_next;
      stream_position <= stream_position_next;
      riff_end <= riff_end_next;
      skip_remaining <= skip_remaining_next;
      chan_count <= chan_count_next;
      rate_value <= rate_value_next;
      align_bytes <= align_bytes_next;
      width_bits <= width_bits_next;
      data_remaining <= data_remaining_next;
      sample_accum <= sample_accum_next;
      byte_in_sample <= byte_in_sample_next;
      chan_index <= chan_index_next;
      byte_in_block <= byte_in_block_next;
    end
  end

endmodule

// ----- sv/wav_queue.sv -----
// Result queue between the parser and the output side.
module wav_queue import wav_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr,
  input  result_t wdata,
  input  logic    rd,
  output result_t rdata,
  output logic    full,
  output logic    empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  result_t           mem [DEPTH];
  logic [AW-1:0]     wptr, rptr;
  logic [AW:0]       count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  // store incoming words
  always_ff @(posedge clk) begin
    if (wr && !full) mem[wptr] <= wdata;
  end

  // advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr && !full) wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      if (rd && !empty) rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      count <= count + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
    end
  end

endmodule
